### src/lsh_pkg.sv
// Shared constants and types for the 3x3 Laplacian sharpen block.
package lsh_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int HEIGHT_MAX = 1024;
    localparam int PIXEL_BITS = 8;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(HEIGHT_MAX);
    localparam int DIM_BITS   = 11;
    localparam int CFG_IDX_BITS = 2;
    localparam int LINE_BITS  = 2 * PIXEL_BITS;
    localparam int SUM_BITS   = PIXEL_BITS + 4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);
    localparam logic [DIM_BITS-1:0] DIM_MIN      = DIM_BITS'(3);

    // Position of one accepted pixel and what its result looks like.
    typedef struct packed {
        logic [COL_BITS-1:0] col;
        logic                emit;
        logic                border;
        logic                last;
    } pos_t;

endpackage

### src/laplacian_sharpen_3x3_top.sv
// Top level of the streaming 3x3 Laplacian sharpen filter.
//
//   Channel  Direction  Ports                                  Contents
//   s_       in         s_tvalid s_tready s_tdata[7:0]         pixel_in
//   m_       out        m_tvalid m_tready m_tdata[7:0] m_tlast pixel_out, out_last
//   cfg_     in         cfg_valid cfg_ready cfg_index cfg_data frame_width, frame_height
//
// One pixel is taken per clock while s_tready is high. A pixel waits in the
// line-store read stage for its RAM word and then moves to the result
// register; the single shared line RAM port pair (one read, one write per
// cycle) sets the one-pixel-per-clock rate.
// Reset (aresetn low, synchronous) restores 640x480, clears the counters,
// the window and both valid flags; line RAM contents are left as they are.
// A stall on m_tready holds the result register and, once the read stage also
// holds a pixel with a result, drops s_tready in the same cycle. Configuration
// writes are always taken; a width or height write restarts the frame.
module laplacian_sharpen_3x3_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] pixel_in
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [7:0] pixel_out
    output logic                                m_tlast,   // out_last
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lsh_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [lsh_pkg::DIM_BITS-1:0]        cfg_data
);
    import lsh_pkg::*;

    pos_t                  pos;
    logic                  in_xfer;

    // Read stage: the pixel waits here for its line RAM word.
    logic                  s1_valid_reg, s1_valid_next;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic [COL_BITS-1:0]   s1_col_reg;
    logic                  s1_emit_reg, s1_border_reg, s1_last_reg;
    logic                  s1_advance;

    // Result register.
    logic                  m_valid_reg, m_valid_next;
    logic [PIXEL_BITS-1:0] m_data_reg;
    logic                  m_last_reg;
    logic                  out_free;

    logic [LINE_BITS-1:0]  line_rdata;
    logic [LINE_BITS-1:0]  line_wdata;
    logic [PIXEL_BITS-1:0] line_a, line_b, sharp;

    assign cfg_ready = 1'b1;

    // The result register frees up when empty or when its transfer completes.
    // A pixel without a result may leave the read stage at any time.
    assign out_free   = !m_valid_reg || m_tready;
    assign s1_advance = s1_valid_reg && (!s1_emit_reg || out_free);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign in_xfer    = s_tvalid && s_tready;

    lsh_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_accept (in_xfer),
        .pos         (pos)
    );

    // Each RAM word holds the pixel from one row up (low byte) and two rows
    // up (high byte) at the same column. The read is issued on the transfer
    // and the word is rewritten as the pixel leaves the read stage; the same
    // column is not touched again before at least three more pixels.
    assign line_a     = line_rdata[PIXEL_BITS-1:0];
    assign line_b     = line_rdata[LINE_BITS-1:PIXEL_BITS];
    assign line_wdata = {line_a, s1_pix_reg};

    lsh_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (s1_advance),
        .waddr (s1_col_reg),
        .wdata (line_wdata),
        .re    (in_xfer),
        .raddr (pos.col),
        .rdata (line_rdata)
    );

    lsh_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .shift   (s1_advance),
        .pix     (s1_pix_reg),
        .line_a  (line_a),
        .line_b  (line_b),
        .sharp   (sharp)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s1_advance && s1_emit_reg) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            s1_pix_reg    <= s_tdata;
            s1_col_reg    <= pos.col;
            s1_emit_reg   <= pos.emit;
            s1_border_reg <= pos.border;
            s1_last_reg   <= pos.last;
        end
        if (s1_advance && s1_emit_reg) begin
            m_data_reg <= s1_border_reg ? '0 : sharp;
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

### src/lsh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/lsh_ctrl.sv
// Frame geometry registers, raster counters and border/emit decode.
module lsh_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [lsh_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [lsh_pkg::DIM_BITS-1:0]        cfg_data,
    input  logic                                item_accept,
    output lsh_pkg::pos_t                       pos
);
    import lsh_pkg::*;

    logic [DIM_BITS-1:0] width_reg, width_next;
    logic [DIM_BITS-1:0] height_reg, height_next;
    logic [COL_BITS-1:0] col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;

    logic [DIM_BITS-1:0] w_eff, h_eff, w_m1, h_m1;
    logic [DIM_BITS-1:0] c, r, orow, ocol;
    logic                last;

    // Clamp the programmed geometry to the supported range.
    always_comb begin
        w_eff = width_reg;
        if (width_reg < DIM_MIN) begin
            w_eff = DIM_MIN;
        end else if (width_reg > DIM_BITS'(MAX_WIDTH)) begin
            w_eff = DIM_BITS'(MAX_WIDTH);
        end
        h_eff = height_reg;
        if (height_reg < DIM_MIN) begin
            h_eff = DIM_MIN;
        end else if (height_reg > DIM_BITS'(HEIGHT_MAX)) begin
            h_eff = DIM_BITS'(HEIGHT_MAX);
        end
        w_m1 = w_eff - DIM_BITS'(1);
        h_m1 = h_eff - DIM_BITS'(1);
    end

    // Output position trails the input by one line plus one pixel.
    always_comb begin
        c = DIM_BITS'(col_reg);
        r = DIM_BITS'(row_reg);
        if (c > w_m1) begin
            c = w_m1;
        end
        if (r > h_m1) begin
            r = h_m1;
        end
        if (c != '0) begin
            orow = r - DIM_BITS'(1);
            ocol = c - DIM_BITS'(1);
        end else begin
            orow = (r >= DIM_BITS'(2)) ? r - DIM_BITS'(2) : '0;
            ocol = w_m1;
        end
        last       = (r == h_m1) && (c == w_m1);
        pos.col    = c[COL_BITS-1:0];
        pos.emit   = (r >= DIM_BITS'(2)) || ((r == DIM_BITS'(1)) && (c != '0));
        pos.border = (orow == '0) || (orow == h_m1) || (ocol == '0) || (ocol == w_m1);
        pos.last   = last;
    end

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH: begin
                    width_next = cfg_data;
                    col_next   = '0;
                    row_next   = '0;
                end
                CFG_FRAME_HEIGHT: begin
                    height_next = cfg_data;
                    col_next    = '0;
                    row_next    = '0;
                end
                default: begin
                end
            endcase
        end else if (item_accept) begin
            if (c == w_m1) begin
                col_next = '0;
                row_next = last ? '0 : ROW_BITS'(r + DIM_BITS'(1));
            end else begin
                col_next = COL_BITS'(c + DIM_BITS'(1));
                row_next = r[ROW_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

### src/lsh_window.sv
// Window taps of the 3x3 neighborhood and the saturating sharpen sum.
module lsh_window (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             shift,
    input  logic [lsh_pkg::PIXEL_BITS-1:0]   pix,
    input  logic [lsh_pkg::PIXEL_BITS-1:0]   line_a,
    input  logic [lsh_pkg::PIXEL_BITS-1:0]   line_b,
    output logic [lsh_pkg::PIXEL_BITS-1:0]   sharp
);
    import lsh_pkg::*;

    // Only the taps that feed the cross-shaped kernel are kept.
    logic [PIXEL_BITS-1:0] up_next_reg;
    logic [PIXEL_BITS-1:0] mid_reg, right_reg;
    logic [PIXEL_BITS-1:0] down_next_reg;
    logic signed [SUM_BITS-1:0] sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_next_reg   <= '0;
            mid_reg       <= '0;
            right_reg     <= '0;
            down_next_reg <= '0;
        end else if (shift) begin
            up_next_reg   <= line_b;
            mid_reg       <= right_reg;
            right_reg     <= line_a;
            down_next_reg <= pix;
        end
    end

    // Computed on the window as it stands before this shift, plus the incoming line_a tap.
    always_comb begin
        sum = $signed({4'b0, right_reg} + ({4'b0, right_reg} << 2))
            - $signed({4'b0, up_next_reg}) - $signed({4'b0, down_next_reg})
            - $signed({4'b0, mid_reg}) - $signed({4'b0, line_a});
        if (sum[SUM_BITS-1]) begin
            sharp = '0;
        end else if (sum > $signed(SUM_BITS'((1 << PIXEL_BITS) - 1))) begin
            sharp = '1;
        end else begin
            sharp = sum[PIXEL_BITS-1:0];
        end
    end

endmodule
